### src/sfa_pkg.sv
package sfa_pkg;

  localparam int FRAME_DEPTH = 32;
  localparam int IDX_W       = $clog2(FRAME_DEPTH);
  localparam int ADDR_W      = IDX_W + 1;
  localparam int BYTE_W      = 8;
  localparam int CFG_LEN_W   = 5;
  localparam int CMP_W       = (IDX_W > CFG_LEN_W) ? IDX_W : CFG_LEN_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [CFG_LEN_W-1:0] MIN_CHECK_FLOOR = CFG_LEN_W'(3);

  localparam logic [BYTE_W-1:0]    DELIM_RST  = 8'h0A;
  localparam logic [BYTE_W-1:0]    MARKER_RST = 8'hFE;
  localparam logic [CFG_LEN_W-1:0] MINCHK_RST = CFG_LEN_W'(7);
  localparam logic [CFG_LEN_W-1:0] FLUSH_RST  = CFG_LEN_W'(31);

  typedef enum logic [1:0] {
    CAUSE_DELIM = 2'd0,
    CAUSE_CRC   = 2'd1,
    CAUSE_LEN   = 2'd2
  } cause_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM  = 2'd0,
    REG_MARKER = 2'd1,
    REG_MINCHK = 2'd2,
    REG_FLUSH  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } back_state_e;

  // closed frame handed from front to back
  typedef struct packed {
    logic             bank;
    logic [IDX_W-1:0] len;
    cause_e           cause;
  } desc_t;

  // back tells front that a buffer is drained
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/sfa_frame_mem.sv
module sfa_frame_mem
  import sfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [2*FRAME_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read register only moves on a read, so it holds under output stall
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/sfa_desc_fifo.sv
module sfa_desc_fifo
  import sfa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t wdata_i,
  input  logic  pop_i,
  output desc_t rdata_o,
  output logic  empty_o,
  output logic  full_o
);

  desc_t      slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = slot_q[rptr_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

### src/sfa_front.sv
module sfa_front
  import sfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [BYTE_W-1:0]     in_byte_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output desc_t                 desc_o,
  input  release_t              rel_i,
  output logic                  mem_we_o,
  output logic [ADDR_W-1:0]     mem_waddr_o
);

  logic [BYTE_W-1:0]    delim_q, marker_q;
  logic [CFG_LEN_W-1:0] minchk_q, flush_q;

  logic [IDX_W-1:0]  len_q, len_d;
  logic [15:0]       crc_q, crc_d;
  logic [BYTE_W-1:0] first_q, first_d;
  logic [BYTE_W-1:0] b1_q, b2_q;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;

  logic              accept;
  logic [IDX_W-1:0]  len_new;
  logic [15:0]       crc_new;
  logic [BYTE_W-1:0] first_b;
  logic [CFG_LEN_W-1:0] min_eff;
  logic [CMP_W-1:0]  len_cmp;
  logic              hit_delim, hit_crc, hit_len, close;
  cause_e            cause;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= DELIM_RST;
      marker_q <= MARKER_RST;
      minchk_q <= MINCHK_RST;
      flush_q  <= FLUSH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DELIM:  delim_q  <= cfg_data_i[BYTE_W-1:0];
        REG_MARKER: marker_q <= cfg_data_i[BYTE_W-1:0];
        REG_MINCHK: minchk_q <= cfg_data_i[CFG_LEN_W-1:0];
        REG_FLUSH:  flush_q  <= cfg_data_i[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !busy_q[bank_q] && !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    len_new = len_q + IDX_W'(1);
    len_cmp = CMP_W'(len_new);
    first_b = (len_q == '0) ? in_byte_i : first_q;
    // byte two places back joins the CRC once the frame holds three bytes
    crc_new = (len_q >= IDX_W'(2)) ? crc_feed(crc_q, b2_q) : crc_q;
    min_eff = (minchk_q < MIN_CHECK_FLOOR) ? MIN_CHECK_FLOOR : minchk_q;

    hit_delim = (in_byte_i == delim_q) && (first_b != marker_q);
    hit_crc   = (len_cmp >= CMP_W'(min_eff)) && (b1_q == crc_new[7:0])
                && (in_byte_i == crc_new[15:8]);
    hit_len   = (len_cmp >= CMP_W'(flush_q)) || (len_new >= IDX_W'(FRAME_DEPTH - 1));

    close = hit_delim || hit_crc || hit_len;
    if (hit_delim) begin
      cause = CAUSE_DELIM;
    end else if (hit_crc) begin
      cause = CAUSE_CRC;
    end else begin
      cause = CAUSE_LEN;
    end
  end

  always_comb begin
    len_d   = len_q;
    crc_d   = crc_q;
    first_d = first_q;
    bank_d  = bank_q;
    busy_d  = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      first_d = first_b;
      if (close) begin
        len_d  = '0;
        crc_d  = CRC_INIT;
        bank_d = ~bank_q;
        busy_d[bank_q] = 1'b1;
      end else begin
        len_d = len_new;
        crc_d = crc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      crc_q  <= CRC_INIT;
      bank_q <= 1'b0;
      busy_q <= 2'b00;
    end else begin
      len_q  <= len_d;
      crc_q  <= crc_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    if (accept) begin
      b1_q <= in_byte_i;
      b2_q <= b1_q;
    end
  end

  assign mem_we_o     = accept;
  assign mem_waddr_o  = {bank_q, len_q};
  assign push_o       = accept && close;
  assign desc_o.bank  = bank_q;
  assign desc_o.len   = len_new;
  assign desc_o.cause = cause;

endmodule

### src/sfa_back.sv
module sfa_back
  import sfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fifo_empty_i,
  input  desc_t             desc_i,
  output logic              pop_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_raddr_o,
  output release_t          rel_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_last_o,
  output cause_e            out_cause_o
);

  back_state_e      state_q, state_d;
  desc_t            desc_q;
  logic [IDX_W-1:0] idx_q;
  logic             valid_q;
  logic             last_q;
  cause_e           cause_q;

  logic issue_ok, issue, is_last;

  assign issue_ok = !valid_q || out_ready_i;
  assign is_last  = (idx_q == desc_q.len - IDX_W'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!fifo_empty_i) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (issue_ok && is_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    issue       = 1'b0;
    rel_o.valid = 1'b0;
    rel_o.bank  = desc_q.bank;
    case (state_q)
      BK_IDLE: begin
        pop_o = !fifo_empty_i;
      end
      BK_DRAIN: begin
        issue = issue_ok;
        // buffer is free once its last byte sits in the read register
        rel_o.valid = issue_ok && is_last;
      end
      default: ;
    endcase
  end

  assign mem_re_o    = issue;
  assign mem_raddr_o = {desc_q.bank, idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (issue) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      desc_q <= desc_i;
      idx_q  <= '0;
    end else if (issue) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (issue) begin
      last_q  <= is_last;
      cause_q <= desc_q.cause;
    end
  end

  assign out_valid_o = valid_q;
  assign out_last_o  = last_q;
  assign out_cause_o = cause_q;

endmodule

### src/serial_frame_assembler_modbus_crc.sv
// Serial frame assembler with Modbus RTU CRC-16 framing. Received bytes enter
// one per cycle and are written into one of two frame buffers. A frame closes on
// the delimiter (unless its first byte is the binary marker), on a matching
// CRC-16/MODBUS trailer (low byte first) once the frame is min_check_length
// long (at least 3), or on reaching flush_length or FRAME_DEPTH - 1 bytes.
// The closed frame then comes out byte by byte with tlast on its final byte and
// the close cause in tuser. Input takes one byte per cycle while s_axis_tready
// is high; output is paced by m_axis_tready and the single read port of the
// frame memory. The input stalls only while both buffers hold frames whose
// last byte has not yet been read out of the frame memory. Configuration must
// be written only while the block is idle; the block does not enforce this.
module serial_frame_assembler_modbus_crc
  import sfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] frame_byte
  output logic                  m_axis_tlast,
  output logic [1:0]            m_axis_tuser    // [1:0] close_cause
);

  logic              fifo_full, fifo_empty, push, pop;
  desc_t             desc_in, desc_out;
  release_t          rel;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  cause_e            out_cause;

  sfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .desc_o      (desc_in),
    .rel_i       (rel),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr)
  );

  sfa_desc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (desc_in),
    .pop_i   (pop),
    .rdata_o (desc_out),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  sfa_frame_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (m_axis_tdata)
  );

  sfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .desc_i       (desc_out),
    .pop_o        (pop),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .rel_o        (rel),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_last_o   (m_axis_tlast),
    .out_cause_o  (out_cause)
  );

  assign m_axis_tuser = out_cause;

endmodule

### sim/frame_monitor.sv
`timescale 1ns / 1ps

module frame_monitor
  import sfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [7:0]            m_axis_tdata,   // [7:0] frame_byte
  input  logic                  m_axis_tlast,
  input  logic [1:0]            m_axis_tuser,   // [1:0] close_cause
  output int                    beats_due_o,
  output int                    open_len_o,
  output int                    failures_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cause_e     cause;
  } frame_beat_t;

  frame_beat_t beats_due[$];

  // shadow of the block's frame state and registers
  logic [7:0]           rx_store [FRAME_DEPTH];
  int                   open_len = 0;
  logic [15:0]          crc_acc = CRC_INIT;
  logic [7:0]           delim_r = DELIM_RST;
  logic [7:0]           marker_r = MARKER_RST;
  logic [CFG_LEN_W-1:0] minchk_r = MINCHK_RST;
  logic [CFG_LEN_W-1:0] flush_r = FLUSH_RST;
  int                   failures = 0;

  function automatic logic [15:0] crc_absorb(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // append one byte; when the frame closes, queue every byte of it
  task automatic absorb_rx_byte(input logic [7:0] b);
    int     n;
    int     chk;
    logic   shut;
    cause_e why;
    rx_store[open_len] = b;
    n = open_len + 1;
    open_len = n;
    // running CRC trails the newest byte by two (the candidate trailer)
    if (n >= 3) crc_acc = crc_absorb(crc_acc, rx_store[n-3]);
    chk = (minchk_r < 3) ? 3 : int'(minchk_r);
    shut = 1'b1;
    why = CAUSE_LEN;
    if (b == delim_r && rx_store[0] != marker_r) begin
      why = CAUSE_DELIM;
    end else if (n >= chk && rx_store[n-2] == crc_acc[7:0] && rx_store[n-1] == crc_acc[15:8]) begin
      why = CAUSE_CRC;
    end else if (n >= int'(flush_r) || n >= FRAME_DEPTH - 1) begin
      why = CAUSE_LEN;
    end else begin
      shut = 1'b0;
    end
    if (shut) begin
      for (int k = 0; k < n; k++) begin
        beats_due.push_back('{data: rx_store[k], last: (k == n - 1), cause: why});
      end
      open_len = 0;
      crc_acc = CRC_INIT;
    end
  endtask

  task automatic flag_failure(input string what, input frame_beat_t want);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s: want data %02h last %0d cause %0d, got data %02h last %0d cause %0d",
               $realtime, what, want.data, want.last, want.cause,
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_beat_t want;
    if (!rst_ni) begin
      beats_due.delete();
      open_len = 0;
      crc_acc = CRC_INIT;
      delim_r = DELIM_RST;
      marker_r = MARKER_RST;
      minchk_r = MINCHK_RST;
      flush_r = FLUSH_RST;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (beats_due.size() == 0) begin
          flag_failure("unexpected frame byte", '0);
        end else begin
          want = beats_due.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tlast !== want.last ||
              m_axis_tuser !== want.cause) begin
            flag_failure("frame byte mismatch", want);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_DELIM:  delim_r = cfg_data_i;
          REG_MARKER: marker_r = cfg_data_i;
          REG_MINCHK: minchk_r = cfg_data_i[CFG_LEN_W-1:0];
          REG_FLUSH:  flush_r = cfg_data_i[CFG_LEN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) absorb_rx_byte(s_axis_tdata);
    end
    beats_due_o = beats_due.size();
    open_len_o = open_len;
    failures_o = failures;
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;

  typedef logic [7:0] byte_q_t[$];

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] rx_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // [7:0] frame_byte
  logic                  m_axis_tlast;
  logic [1:0]            m_axis_tuser;        // [1:0] close_cause

  int beats_due;
  int open_len;
  int failures;
  int burst_left = 0;
  int idle_cycles = 0;
  bit long_hold_req = 1'b0;

  serial_frame_assembler_modbus_crc u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  frame_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .beats_due_o   (beats_due),
    .open_len_o    (open_len),
    .failures_o    (failures)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // no transaction on either side for too long means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: ready duty cycle changes in spans, plus one long hold-off on request
  initial begin : frame_sink
    int pct;
    int span;
    pct = 100;
    span = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      if (span == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 75;
          2: pct = 40;
          default: pct = 15;
        endcase
        span = $urandom_range(16, 80);
      end
      span--;
      m_axis_tready <= ($urandom_range(0, 99) < pct);
    end
  end

  function automatic byte_q_t with_crc(input byte_q_t body);
    logic [15:0] acc;
    byte_q_t     framed;
    acc = CRC_INIT;
    foreach (body[i]) begin
      acc ^= {8'h00, body[i]};
      for (int k = 0; k < 8; k++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
    end
    framed = body;
    framed.push_back(acc[7:0]);
    framed.push_back(acc[15:8]);
    return framed;
  endfunction

  // called at a rising edge; returns at the edge of the transaction with tvalid still high
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_seq(input byte_q_t seq);
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  // close any open frame with filler, then let the output drain completely
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (open_len != 0) begin
      @(posedge clk_i);
      push_byte(8'($urandom_range(0, 255)));
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    while (beats_due != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] delim, input logic [7:0] marker,
                              input logic [4:0] minchk, input logic [4:0] flush);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_DELIM;
    cfg_data_i <= delim;
    @(posedge clk_i);
    cfg_idx_i <= REG_MARKER;
    cfg_data_i <= marker;
    @(posedge clk_i);
    cfg_idx_i <= REG_MINCHK;
    cfg_data_i <= CFG_DATA_W'(minchk);
    @(posedge clk_i);
    cfg_idx_i <= REG_FLUSH;
    cfg_data_i <= CFG_DATA_W'(flush);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] delim;
    logic [7:0] marker;
    logic [4:0] minchk;
    logic [4:0] flush;
    int         chk_eff;
    int         count;
    int         kind;
    int         body_len;
    byte_q_t    seq;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: text frame, then marker-led frame with a newline inside and a CRC trailer
    seq = {8'h48, 8'h69, 8'h0A};
    send_seq(seq);
    seq = {8'hFE, 8'h00, 8'hFF, 8'h0A, 8'h55};
    send_seq(with_crc(seq));
    settle();

    // check length below the floor acts as 3; marker 0x00 suppresses delimiter 0xFF
    program_regs(8'hFF, 8'h00, 5'd0, 5'd31);
    seq = {8'h7E};
    send_seq(with_crc(seq));
    seq = {8'h01, 8'hFF};
    send_seq(seq);
    seq = {8'h00, 8'hFF};
    send_seq(with_crc(seq));
    settle();

    // zero flush length: every byte closes, delimiter still wins over length
    program_regs(8'h80, 8'hFE, 5'd31, 5'd0);
    seq = {8'h00, 8'h80, 8'hFE};
    send_seq(seq);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin delim = 8'h0A; marker = 8'hFE; minchk = 5'd7;  flush = 5'd31; end
        1: begin delim = 8'h00; marker = 8'hFF; minchk = 5'd3;  flush = 5'd31; end
        2: begin delim = 8'hFF; marker = 8'h00; minchk = 5'd31; flush = 5'd1;  end
        3: begin delim = 8'h0A; marker = 8'hFE; minchk = 5'd2;  flush = 5'd31; end
        default: begin
          delim = 8'($urandom_range(0, 255));
          marker = 8'($urandom_range(0, 255));
          minchk = 5'($urandom_range(0, 31));
          flush = 5'($urandom_range(0, 31));
        end
      endcase
      program_regs(delim, marker, minchk, flush);
      chk_eff = (minchk < 3) ? 3 : int'(minchk);
      // short frames while the output is held off fill both buffers
      if (ph == 1) long_hold_req = 1'b1;
      count = 0;
      while (count < 12) begin
        kind = $urandom_range(0, 9);
        seq = {};
        if (kind < 4) begin
          body_len = $urandom_range(0, 6);
          repeat (body_len) seq.push_back(8'($urandom_range(0, 255)));
          seq.push_back(delim);
        end else if (kind < 8) begin
          body_len = $urandom_range(1, 8);
          if (body_len + 2 < chk_eff) body_len = chk_eff - 2;
          seq.push_back($urandom_range(0, 1) ? marker : 8'($urandom_range(0, 255)));
          repeat (body_len - 1) seq.push_back(8'($urandom_range(0, 255)));
          seq = with_crc(seq);
        end else begin
          repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
        end
        send_seq(seq);
        count += seq.size();
      end
      settle();
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (beats_due != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
